/* src/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the color blob centroid block
// Item format between front and back, color indexes, table ids and the
// state encoding of the ordering engine.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int FRAME_WIDTH = 1024;

  localparam int COL_W = 10;
  localparam int PIX_W = 8;
  localparam int WIN_W = 48;
  localparam int SUM_W = 30;
  localparam int CNT_W = 21;
  localparam int PROD_W = SUM_W + CNT_W;
  localparam int NUM_COLORS = 3;

  localparam logic [COL_W-1:0] COL_CLAMP = COL_W'(FRAME_WIDTH - 1);

  // Color slots
  localparam int C_RED = 0;
  localparam int C_BLUE = 1;
  localparam int C_GREEN = 2;

  // Table ids
  localparam logic [1:0] ID_BLUE = 2'd1;
  localparam logic [1:0] ID_GREEN = 2'd2;
  localparam logic [1:0] ID_RED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_RED_WIN = 2'd0;
  localparam logic [1:0] REG_BLUE_WIN = 2'd1;
  localparam logic [1:0] REG_GREEN_WIN = 2'd2;

  localparam logic [WIN_W-1:0] RED_WIN_RST = 48'h0000640AFFFF;
  localparam logic [WIN_W-1:0] BLUE_WIN_RST = 48'h640000FF3232;
  localparam logic [WIN_W-1:0] GREEN_WIN_RST = 48'h00640032FF32;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  // Cross-product slots: sum of first color times count of second
  localparam int P_RB = 0;
  localparam int P_BR = 1;
  localparam int P_RG = 2;
  localparam int P_GR = 3;
  localparam int P_BG = 4;
  localparam int P_GB = 5;
  localparam int NUM_PROD = 6;

  typedef struct packed {
    logic [NUM_COLORS-1:0] match;
    logic [COL_W-1:0]      col;
    logic                  frame_end;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_CMP,
    ENG_EMIT
  } eng_state_t;

endpackage

/* src/color_blob_centroid_order.sv */
// ----------------------------------------------------------------------------
// color_blob_centroid_order: order three color blobs by mean column
// Classifies BGR pixels against three color windows and, per frame, emits
// the color table ids from rightmost to leftmost blob.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel transaction per cycle when in_ready (B, G, R, column, frame_end).
//   out_* : three transactions per frame, table_id from largest to smallest
//           mean column; out_last_id marks the third.
//   cfg_* : window writes, index 0 red, 1 blue, 2 green; always ready.
// Throughput: one pixel per cycle while the queue has room. A frame end
//   waits in the queue until the ordering engine has delivered the previous
//   frame's three ids. Sequence: a frame-end pixel leaves the queue once
//   the engine is idle, the products are registered in the multiply state
//   and the ids in the compare state, after which the first id is valid;
//   the three ids go out on consecutive cycles when the receiver takes them.
// Reset: windows return to their defaults, sums, counts and queue clear.
// Stall: while out_ready is low the ids hold; pixels keep accumulating until
//   a second frame end reaches the head of the queue and the queue fills,
//   then in_ready drops.
// ----------------------------------------------------------------------------
module color_blob_centroid_order
  import cbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [WIN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel_blue,
  input  logic [PIX_W-1:0] in_pixel_green,
  input  logic [PIX_W-1:0] in_pixel_red,
  input  logic [COL_W-1:0] in_column,
  input  logic             in_frame_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_table_id,
  output logic             out_last_id
);

  item_t     front_item;
  item_t     q_item;
  q_status_t q_status;
  logic      q_valid;
  logic      q_pop;

  // Window registers accept every write.
  assign cfg_ready = 1'b1;

  cbc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .in_column      (in_column),
    .in_frame_end   (in_frame_end),
    .item           (front_item)
  );

  // Accept pixels whenever the queue has room.
  assign in_ready = !q_status.full;
  assign q_valid = !q_status.empty;

  cbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_valid),
    .wr_item (front_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .status  (q_status)
  );

  cbc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_table_id (out_table_id),
    .out_last_id  (out_last_id)
  );

  // Never offer an invalid table id.
  a_valid_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_table_id == ID_BLUE || out_table_id == ID_GREEN ||
                   out_table_id == ID_RED))
    else $error("invalid table id on output");

  // Only a frame end may hold at the head of the queue.
  a_stall_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_pop) |-> q_item.frame_end)
    else $error("pixel held at queue head");

  // Back-pressure to the source implies queued work.
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // The last id closes a frame: the next cycle shows no leftover id.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_id) |=> !out_valid)
    else $error("output still valid after last id");

endmodule

/* src/cbc_front.sv */
// ----------------------------------------------------------------------------
// cbc_front: window registers and pixel classification
// Holds the three color windows and turns each pixel into a match mask and
// a clamped column.
// ----------------------------------------------------------------------------
module cbc_front
  import cbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [WIN_W-1:0] cfg_data,
  input  logic [PIX_W-1:0] in_pixel_blue,
  input  logic [PIX_W-1:0] in_pixel_green,
  input  logic [PIX_W-1:0] in_pixel_red,
  input  logic [COL_W-1:0] in_column,
  input  logic             in_frame_end,
  output item_t            item
);

  logic [WIN_W-1:0] red_win_r;
  logic [WIN_W-1:0] blue_win_r;
  logic [WIN_W-1:0] green_win_r;

  function automatic logic win_match(input logic [WIN_W-1:0] w,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] g,
                                     input logic [PIX_W-1:0] r);
    return (b >= w[47:40]) && (b <= w[23:16]) &&
           (g >= w[39:32]) && (g <= w[15:8]) &&
           (r >= w[31:24]) && (r <= w[7:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_win_r <= RED_WIN_RST;
      blue_win_r <= BLUE_WIN_RST;
      green_win_r <= GREEN_WIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RED_WIN:   red_win_r <= cfg_data;
        REG_BLUE_WIN:  blue_win_r <= cfg_data;
        REG_GREEN_WIN: green_win_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.match[C_RED] = win_match(red_win_r, in_pixel_blue, in_pixel_green, in_pixel_red);
    item.match[C_BLUE] = win_match(blue_win_r, in_pixel_blue, in_pixel_green, in_pixel_red);
    item.match[C_GREEN] = win_match(green_win_r, in_pixel_blue, in_pixel_green,
                                    in_pixel_red);
    // clamp columns past the frame edge
    item.col = (int'(in_column) >= FRAME_WIDTH) ? COL_CLAMP : in_column;
    item.frame_end = in_frame_end;
  end

endmodule

/* src/cbc_queue.sv */
// ----------------------------------------------------------------------------
// cbc_queue: short FIFO between classification and accumulation
// Lets the front keep taking pixels while the back holds a frame end.
// ----------------------------------------------------------------------------
module cbc_queue
  import cbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  item_t     wr_item,
  input  logic      rd_en,
  output item_t     rd_item,
  output q_status_t status
);

  item_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign status.full = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* src/cbc_back.sv */
// ----------------------------------------------------------------------------
// cbc_back: accumulation and per-frame ordering
// Accumulates column sums and counts, snapshots them at frame end, orders
// the colors by cross-multiplied means and emits three table ids.
// ----------------------------------------------------------------------------
module cbc_back
  import cbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_table_id,
  output logic       out_last_id
);

  logic [SUM_W-1:0]  sum_r      [NUM_COLORS];
  logic [CNT_W-1:0]  cnt_r      [NUM_COLORS];
  logic [SUM_W-1:0]  sum_nxt    [NUM_COLORS];
  logic [CNT_W-1:0]  cnt_nxt    [NUM_COLORS];
  logic [SUM_W-1:0]  snap_sum_r [NUM_COLORS];
  logic [CNT_W-1:0]  snap_cnt_r [NUM_COLORS];
  logic [PROD_W-1:0] prod_r     [NUM_PROD];
  logic [1:0]        ids_r      [NUM_COLORS];
  logic [1:0]        ids_nxt    [NUM_COLORS];
  logic [1:0]        emit_idx_r;
  logic [1:0]        emit_idx_nxt;
  eng_state_t        state_r;
  eng_state_t        state_nxt;
  logic [SUM_W:0]    sum_ext;
  logic              nz_r, nz_b, nz_g;
  logic              gt_rb, gt_br, gt_rg, gt_gr, gt_bg, gt_gb;
  logic              frame_pop;

  // Frame ends wait for the ordering engine; pixels never wait.
  assign q_pop = q_valid && (!q_item.frame_end || (state_r == ENG_IDLE));
  assign frame_pop = q_pop && q_item.frame_end;

  always_comb begin
    for (int c = 0; c < NUM_COLORS; c++) begin
      sum_ext = {1'b0, sum_r[c]} + (SUM_W+1)'(q_item.col);
      sum_nxt[c] = sum_r[c];
      cnt_nxt[c] = cnt_r[c];
      if (q_item.match[c]) begin
        sum_nxt[c] = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        cnt_nxt[c] = (&cnt_r[c]) ? cnt_r[c] : cnt_r[c] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        sum_r[c] <= '0;
        cnt_r[c] <= '0;
      end
    end else if (frame_pop) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        sum_r[c] <= '0;
        cnt_r[c] <= '0;
      end
    end else if (q_pop) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        sum_r[c] <= sum_nxt[c];
        cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  // Snapshot includes the frame's last pixel.
  always_ff @(posedge clk) begin
    if (frame_pop) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        snap_sum_r[c] <= sum_nxt[c];
        snap_cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ENG_MUL) begin
      prod_r[P_RB] <= PROD_W'(snap_sum_r[C_RED]) * PROD_W'(snap_cnt_r[C_BLUE]);
      prod_r[P_BR] <= PROD_W'(snap_sum_r[C_BLUE]) * PROD_W'(snap_cnt_r[C_RED]);
      prod_r[P_RG] <= PROD_W'(snap_sum_r[C_RED]) * PROD_W'(snap_cnt_r[C_GREEN]);
      prod_r[P_GR] <= PROD_W'(snap_sum_r[C_GREEN]) * PROD_W'(snap_cnt_r[C_RED]);
      prod_r[P_BG] <= PROD_W'(snap_sum_r[C_BLUE]) * PROD_W'(snap_cnt_r[C_GREEN]);
      prod_r[P_GB] <= PROD_W'(snap_sum_r[C_GREEN]) * PROD_W'(snap_cnt_r[C_BLUE]);
    end
  end

  // Empty colors compare false both ways.
  always_comb begin
    nz_r = (snap_cnt_r[C_RED] != '0);
    nz_b = (snap_cnt_r[C_BLUE] != '0);
    nz_g = (snap_cnt_r[C_GREEN] != '0);
    gt_rb = nz_r && nz_b && (prod_r[P_RB] > prod_r[P_BR]);
    gt_br = nz_r && nz_b && (prod_r[P_BR] > prod_r[P_RB]);
    gt_rg = nz_r && nz_g && (prod_r[P_RG] > prod_r[P_GR]);
    gt_gr = nz_r && nz_g && (prod_r[P_GR] > prod_r[P_RG]);
    gt_bg = nz_b && nz_g && (prod_r[P_BG] > prod_r[P_GB]);
    gt_gb = nz_b && nz_g && (prod_r[P_GB] > prod_r[P_BG]);
    if (gt_rb && gt_rg) begin
      ids_nxt[0] = ID_RED;
      ids_nxt[1] = gt_bg ? ID_BLUE : ID_GREEN;
      ids_nxt[2] = gt_bg ? ID_GREEN : ID_BLUE;
    end else if (gt_br && gt_bg) begin
      ids_nxt[0] = ID_BLUE;
      ids_nxt[1] = gt_rg ? ID_RED : ID_GREEN;
      ids_nxt[2] = gt_rg ? ID_GREEN : ID_RED;
    end else begin
      ids_nxt[0] = ID_GREEN;
      ids_nxt[1] = gt_rb ? ID_RED : ID_BLUE;
      ids_nxt[2] = gt_rb ? ID_BLUE : ID_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ENG_CMP) begin
      for (int k = 0; k < NUM_COLORS; k++) begin
        ids_r[k] <= ids_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      emit_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    emit_idx_nxt = emit_idx_r;
    out_valid = 1'b0;
    unique case (state_r)
      ENG_IDLE: begin
        if (frame_pop) begin
          state_nxt = ENG_MUL;
        end
      end
      ENG_MUL: state_nxt = ENG_CMP;
      ENG_CMP: begin
        state_nxt = ENG_EMIT;
        emit_idx_nxt = '0;
      end
      ENG_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (emit_idx_r == 2'(NUM_COLORS - 1)) begin
            state_nxt = ENG_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  assign out_table_id = ids_r[emit_idx_r];
  assign out_last_id = (emit_idx_r == 2'(NUM_COLORS - 1));

endmodule

/* verif/tb_color_blob_centroid_order.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_blob_centroid_order: self-checking bench for blob ordering
// Streams pixel frames through several color window settings, predicts the
// three ordered table ids of each frame and checks every id transaction as
// it leaves the block, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------

import cbc_pkg::*;

typedef struct {
  logic [1:0] table_id;
  logic       last_id;
} order_id_t;

// Tracks the per-color column sums and hit counts as the block should, and
// holds the ordered ids owed for every frame end not yet delivered.
class blob_order_board;
  logic [WIN_W-1:0] windows [NUM_COLORS];
  logic [SUM_W-1:0] col_sums [NUM_COLORS];
  logic [CNT_W-1:0] hit_counts [NUM_COLORS];
  order_id_t        expected_ids [$];
  int mismatches;
  int pixels;
  int frames;
  int ids_checked;

  function new();
    windows[C_RED]   = RED_WIN_RST;
    windows[C_BLUE]  = BLUE_WIN_RST;
    windows[C_GREEN] = GREEN_WIN_RST;
    clear_sums();
    mismatches  = 0;
    pixels      = 0;
    frames      = 0;
    ids_checked = 0;
  endfunction

  function void clear_sums();
    for (int c = 0; c < NUM_COLORS; c++) begin
      col_sums[c]   = '0;
      hit_counts[c] = '0;
    end
  endfunction

  function void set_window(logic [1:0] idx, logic [WIN_W-1:0] data);
    case (idx)
      REG_RED_WIN:   windows[C_RED]   = data;
      REG_BLUE_WIN:  windows[C_BLUE]  = data;
      REG_GREEN_WIN: windows[C_GREEN] = data;
      default: ;
    endcase
  endfunction

  // Bytes from the top: lower B, G, R, then upper B, G, R.
  function bit in_window(logic [WIN_W-1:0] w, logic [7:0] b, logic [7:0] g,
                         logic [7:0] r);
    return b >= w[47:40] && b <= w[23:16] &&
           g >= w[39:32] && g <= w[15:8] &&
           r >= w[31:24] && r <= w[7:0];
  endfunction

  function void add_hit(int c, logic [COL_W-1:0] col);
    logic [SUM_W:0] s;
    s = {1'b0, col_sums[c]} + (SUM_W + 1)'(col);
    col_sums[c] = s[SUM_W] ? '1 : s[SUM_W-1:0];
    if (hit_counts[c] != '1) hit_counts[c]++;
  endfunction

  // Mean column of a strictly right of mean column of b; empty colors never win.
  function bit right_of(int a, int b);
    logic [63:0] lhs, rhs;
    if (hit_counts[a] == 0 || hit_counts[b] == 0) return 1'b0;
    lhs = 64'(col_sums[a]) * 64'(hit_counts[b]);
    rhs = 64'(col_sums[b]) * 64'(hit_counts[a]);
    return lhs > rhs;
  endfunction

  function logic [1:0] id_of(int c);
    case (c)
      C_RED:   return ID_RED;
      C_BLUE:  return ID_BLUE;
      default: return ID_GREEN;
    endcase
  endfunction

  function void push_id(int c, logic last);
    order_id_t e;
    e.table_id = id_of(c);
    e.last_id  = last;
    expected_ids.insert(expected_ids.size(), e);
  endfunction

  function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                           logic [COL_W-1:0] col, logic fe);
    logic [COL_W-1:0] x;
    int lead, mid, tail;
    pixels++;
    x = (int'(col) >= FRAME_WIDTH) ? COL_CLAMP : col;
    for (int c = 0; c < NUM_COLORS; c++)
      if (in_window(windows[c], b, g, r)) add_hit(c, x);
    if (!fe) return;
    frames++;
    // Fixed decision chain: red, then blue must be strictly rightmost,
    // otherwise green leads.
    if (right_of(C_RED, C_BLUE) && right_of(C_RED, C_GREEN)) begin
      lead = C_RED;
      if (right_of(C_BLUE, C_GREEN)) begin
        mid = C_BLUE;  tail = C_GREEN;
      end else begin
        mid = C_GREEN; tail = C_BLUE;
      end
    end else if (right_of(C_BLUE, C_RED) && right_of(C_BLUE, C_GREEN)) begin
      lead = C_BLUE;
      if (right_of(C_RED, C_GREEN)) begin
        mid = C_RED;   tail = C_GREEN;
      end else begin
        mid = C_GREEN; tail = C_RED;
      end
    end else begin
      lead = C_GREEN;
      if (right_of(C_RED, C_BLUE)) begin
        mid = C_RED;   tail = C_BLUE;
      end else begin
        mid = C_BLUE;  tail = C_RED;
      end
    end
    push_id(lead, 1'b0);
    push_id(mid, 1'b0);
    push_id(tail, 1'b1);
    clear_sums();
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 20) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_id(logic [1:0] tid, logic last);
    order_id_t e;
    ids_checked++;
    if (expected_ids.size() == 0) begin
      report($sformatf("id %0d last %0d with no frame end pending", tid, last));
      return;
    end
    e = expected_ids.pop_front();
    if (tid !== e.table_id)
      report($sformatf("table_id %0d, want %0d", tid, e.table_id));
    if (last !== e.last_id)
      report($sformatf("last_id %0d, want %0d", last, e.last_id));
  endtask

  task flush_leftovers();
    order_id_t e;
    while (expected_ids.size() != 0) begin
      e = expected_ids.pop_front();
      report($sformatf("id %0d never delivered", e.table_id));
    end
  endtask

  function int pending();
    return expected_ids.size();
  endfunction
endclass

module tb_color_blob_centroid_order;

  localparam logic [1:0]       REG_SPARE  = 2'd3;   // decodes to no window
  localparam int               IDLE_LIMIT = 4000;
  localparam int               LONG_HOLD  = 300;
  localparam int               SETTLE     = 8;
  localparam logic [WIN_W-1:0] WIN_ALL    = 48'h000000FFFFFF;
  localparam logic [WIN_W-1:0] WIN_ZERO   = 48'h000000000000;
  localparam logic [WIN_W-1:0] WIN_ONES   = 48'hFFFFFFFFFFFF;
  localparam logic [WIN_W-1:0] WIN_INVERT = 48'hFFFFFF000000;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [WIN_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] in_pixel_blue;
  logic [PIX_W-1:0] in_pixel_green;
  logic [PIX_W-1:0] in_pixel_red;
  logic [COL_W-1:0] in_column;
  logic             in_frame_end;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_table_id;
  logic             out_last_id;

  blob_order_board board;
  logic steady;          // suppress idling on both sides
  logic long_hold_req;   // ask the receiver for one long hold-off
  int   hold_left;
  int   idle_cycles;
  int   cfg_writes;

  color_blob_centroid_order DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_blue  (in_pixel_blue),
    .in_pixel_green (in_pixel_green),
    .in_pixel_red   (in_pixel_red),
    .in_column      (in_column),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_table_id   (out_table_id),
    .out_last_id    (out_last_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample every handshake at the rising edge; the same edge feeds the
  // watchdog, which counts cycles without any transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        board.set_window(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && in_ready)
        board.note_pixel(in_pixel_blue, in_pixel_green, in_pixel_red, in_column,
                         in_frame_end);
      if (out_valid && out_ready)
        board.check_id(out_table_id, out_last_id);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Receiver: one decision per falling edge, so out_ready changes once a step.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        out_ready     = 1'b0;
        hold_left     = LONG_HOLD - 1;
        long_hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        hold_left = pick_gap();
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one pixel transaction and hold it until accepted. Valid stays high
  // on return so a back-to-back pixel needs no extra edge.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r, input logic [COL_W-1:0] col,
                            input logic fe);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pixel_blue  = b;
    in_pixel_green = g;
    in_pixel_red   = r;
    in_column      = col;
    in_frame_end   = fe;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop the input and hold until every owed id has been delivered.
  task automatic wait_for_ids();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [1:0] idx, input logic [WIN_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Reprogram all three windows once the block has gone quiet.
  task automatic apply_windows(input logic [WIN_W-1:0] red_w,
                               input logic [WIN_W-1:0] blue_w,
                               input logic [WIN_W-1:0] green_w,
                               input bit poke_spare);
    wait_for_ids();
    repeat (SETTLE) @(negedge clk);
    write_window(REG_RED_WIN, red_w);
    write_window(REG_BLUE_WIN, blue_w);
    write_window(REG_GREEN_WIN, green_w);
    if (poke_spare) write_window(REG_SPARE, WIN_W'({$urandom, $urandom}));
    cfg_valid = 1'b0;
  endtask

  // Mostly ordered channel ranges; one in ten reversed draws stays inverted.
  function automatic logic [WIN_W-1:0] random_window();
    logic [7:0] lo [3];
    logic [7:0] hi [3];
    logic [7:0] x, y;
    for (int k = 0; k < 3; k++) begin
      x = 8'($urandom);
      y = 8'($urandom);
      if (x > y && $urandom_range(0, 9) != 0) begin
        lo[k] = y; hi[k] = x;
      end else begin
        lo[k] = x; hi[k] = y;
      end
    end
    return {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  // Channel value inside [lo, hi], biased to the bounds.
  function automatic logic [7:0] pick_in(logic [7:0] lo, logic [7:0] hi);
    int roll;
    if (lo > hi) return 8'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 2) return lo;
    if (roll < 4) return hi;
    return 8'($urandom_range(int'(hi), int'(lo)));
  endfunction

  function automatic logic [COL_W-1:0] near(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return COL_W'(v);
  endfunction

  // Default windows: red (0,0,255), blue (255,0,0), green (0,255,0) hit
  // exactly one color each; black hits none.
  task automatic directed_frames();
    // no color at all: fallback chain gives green, blue, red
    send_pixel(8'd0, 8'd0, 8'd0, 10'd0, 1'b1);
    // red right, blue middle, green left
    send_pixel(8'd0, 8'd0, 8'd255, 10'd1023, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 10'd512, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 10'd0, 1'b1);
    // blue rightmost, then green, then red
    send_pixel(8'd255, 8'd0, 8'd0, 10'd900, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 10'd100, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 10'd500, 1'b1);
    // green rightmost, then red, then blue
    send_pixel(8'd0, 8'd255, 8'd0, 10'd1000, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 10'd600, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 10'd10, 1'b1);
    // red and blue tie on the right: nobody strictly leads
    send_pixel(8'd0, 8'd0, 8'd255, 10'd300, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 10'd300, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 10'd100, 1'b1);
    // white hits nothing; green stays empty and blocks red from leading
    send_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 1'b0);
    send_pixel(8'd5, 8'd200, 8'd255, 10'd1023, 1'b0);
    send_pixel(8'd255, 8'd50, 8'd50, 10'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 10'd512, 1'b1);
    // lone red at the window's lower red bound on the frame end itself
    send_pixel(8'd0, 8'd0, 8'd100, 10'd7, 1'b1);
    // equal means from different counts: red 200/400 against blue 300
    send_pixel(8'd0, 8'd0, 8'd255, 10'd200, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 10'd400, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 10'd300, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 10'd299, 1'b1);
  endtask

  // Frames of random length; pixels land inside a chosen color's window near its
  // center when that color is present in the frame, the rest are noise and extreme values.
  task automatic random_frames(input int pixel_goal);
    int sent, len, c, roll, spread;
    int centers [NUM_COLORS];
    bit tie;
    logic [2:0] present;
    logic [7:0] b, g, r;
    logic [COL_W-1:0] col;
    logic [WIN_W-1:0] w;
    sent = 0;
    while (sent < pixel_goal) begin
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
      present = 3'($urandom_range(0, 7));
      tie     = ($urandom_range(0, 5) == 0);
      spread  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      for (int k = 0; k < NUM_COLORS; k++)
        centers[k] = tie ? (k == 0 ? $urandom_range(0, 1023) : centers[0])
                         : $urandom_range(0, 1023);
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        c    = $urandom_range(0, NUM_COLORS - 1);
        if (roll < 75 && present[c]) begin
          w   = board.windows[c];
          b   = pick_in(w[47:40], w[23:16]);
          g   = pick_in(w[39:32], w[15:8]);
          r   = pick_in(w[31:24], w[7:0]);
          col = near(centers[c], spread);
        end else if (roll < 90) begin
          b   = 8'($urandom);
          g   = 8'($urandom);
          r   = 8'($urandom);
          col = COL_W'($urandom);
        end else begin
          b   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          g   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          r   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          col = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end
        send_pixel(b, g, r, col, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    board          = new();
    steady         = 1'b0;
    long_hold_req  = 1'b0;
    idle_cycles    = 0;
    cfg_writes     = 0;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_RED_WIN;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_pixel_blue  = '0;
    in_pixel_green = '0;
    in_pixel_red   = '0;
    in_column      = '0;
    in_frame_end   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Default windows straight out of reset.
    directed_frames();
    random_frames(60);
    // Sender pause: let the block drain completely, then resume.
    wait_for_ids();
    random_frames(40);

    // Every window open: all colors tie, run without any idling.
    apply_windows(WIN_ALL, WIN_ALL, WIN_ALL, 1'b0);
    steady = 1'b1;
    random_frames(40);
    wait_for_ids();
    steady = 1'b0;

    apply_windows(random_window(), random_window(), random_window(), 1'b0);
    random_frames(70);

    // Single-point windows: only black or only white matches.
    apply_windows(WIN_ZERO, WIN_ZERO, WIN_ONES, 1'b0);
    random_frames(30);

    // Inverted windows never match; also poke the unused register index.
    apply_windows(WIN_INVERT, WIN_INVERT, WIN_INVERT, 1'b1);
    random_frames(25);

    // Long receiver hold-off while pixels keep coming: fill the block.
    apply_windows(random_window(), random_window(), random_window(), 1'b0);
    long_hold_req = 1'b1;
    random_frames(80);

    apply_windows(RED_WIN_RST, BLUE_WIN_RST, GREEN_WIN_RST, 1'b0);
    random_frames(30);

    wait_for_ids();
    repeat (2 * SETTLE) @(negedge clk);
    board.flush_leftovers();

    $display("Covered %0d pixels in %0d frames across %0d window writes,",
             board.pixels, board.frames, cfg_writes);
    $display("with %0d ordered ids checked and %0d mismatches.",
             board.ids_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
